// ----- design/pqid_pkg.sv -----
package pqid_pkg;

  typedef enum logic [2:0] {
    OP_ADD_CQ    = 3'd0,
    OP_ADD_SQ    = 3'd1,
    OP_FIND_CQ   = 3'd2,
    OP_FIND_SQ   = 3'd3,
    OP_REMOVE_CQ = 3'd4,
    OP_REMOVE_SQ = 3'd5,
    OP_PROBE_CQ  = 3'd6,
    OP_PROBE_SQ  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  localparam int unsigned QID_BITS  = 16;
  localparam int unsigned SLOT_BITS = 8;
  localparam int unsigned WORD_BITS = 64;

endpackage

// ----- design/pqid_prio_enc.sv -----
module pqid_prio_enc #(
  parameter int unsigned N = 16,
  parameter int unsigned W = 4
) (
  input  logic [N-1:0] vec,
  output logic [W-1:0] idx,
  output logic         any
);

  // lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = W'(i);
      end
    end
  end

  assign any = |vec;

endmodule

// ----- design/paired_queue_id_table_unit.sv -----
// channel | signals                                            | word
// in      | in_valid, in_ready, req_type, key_qid, new_sq_qid, | one request
//         | probe_slot, attr_in                                |
// out     | out_valid, out_ready, ok, slot_out, attr_out       | one result
//
// a result is built in steps once its word is accepted: the accept edge captures
// the match vectors, the update step encodes the slot, updates the tables and reads the
// attribute memory, and the response step loads the output register.
// one word in flight; in_ready only when idle, so a new word waits until the response step is done.
// reset clears both id tables at once; no clearing pass, attributes are not reset.
// an untaken result holds the output register and the next one waits in the last step.
module paired_queue_id_table_unit #(
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned ATTR_BITS   = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      req_type,
  input  logic [pqid_pkg::QID_BITS-1:0]   key_qid,
  input  logic [pqid_pkg::QID_BITS-1:0]   new_sq_qid,
  input  logic [pqid_pkg::SLOT_BITS-1:0]  probe_slot,
  input  logic [pqid_pkg::WORD_BITS-1:0]  attr_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok,
  output logic [pqid_pkg::SLOT_BITS-1:0]  slot_out,
  output logic [pqid_pkg::WORD_BITS-1:0]  attr_out
);

  localparam int unsigned SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  pqid_pkg::state_t state, state_next;

  logic [pqid_pkg::QID_BITS-1:0] cq_ids [QUEUE_SLOTS];
  logic [pqid_pkg::QID_BITS-1:0] sq_ids [QUEUE_SLOTS];
  logic [ATTR_BITS-1:0]          cq_attr_mem [QUEUE_SLOTS];
  logic [ATTR_BITS-1:0]          sq_attr_mem [QUEUE_SLOTS];
  logic [ATTR_BITS-1:0]          cq_rd;
  logic [ATTR_BITS-1:0]          sq_rd;

  // captured request
  pqid_pkg::op_t                 op;
  logic [pqid_pkg::QID_BITS-1:0] key;
  logic [pqid_pkg::QID_BITS-1:0] new_sq;
  logic [ATTR_BITS-1:0]          attr;
  logic [SLOT_W-1:0]             probe_idx;
  logic [QUEUE_SLOTS-1:0]        sel_vec;
  logic [QUEUE_SLOTS-1:0]        sq_free_vec;
  logic                          pre_ok;

  // result of the update step
  logic                          res_ok;
  logic [SLOT_W-1:0]             res_slot;
  logic                          res_find;
  logic                          res_sq;

  logic [QUEUE_SLOTS-1:0] cq_hit, sq_hit, cq_free, sq_free;
  logic [QUEUE_SLOTS-1:0] sel_in;
  logic                   pre_ok_in;
  logic                   probe_hit;
  logic [SLOT_W-1:0]      probe_in;
  logic [SLOT_W-1:0]      enc_slot;
  logic                   enc_any;
  logic                   exec_ok;
  logic [SLOT_W-1:0]      exec_slot;
  logic                   in_fire;
  logic                   resp_go;
  pqid_pkg::op_t          req_op;

  assign req_op   = pqid_pkg::op_t'(req_type);
  assign in_ready = (state == pqid_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign resp_go  = (state == pqid_pkg::ST_RESP) && (!out_valid || out_ready);
  assign probe_in = probe_slot[SLOT_W-1:0];

  always_comb begin
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      cq_hit[i]  = (key_qid != '0) && (cq_ids[i] == key_qid);
      sq_hit[i]  = (key_qid != '0) && (sq_ids[i] == key_qid);
      cq_free[i] = (cq_ids[i] == '0);
      sq_free[i] = (sq_ids[i] == '0);
    end
  end

  always_comb begin
    probe_hit = 1'b0;
    if ({1'b0, probe_slot} < (pqid_pkg::SLOT_BITS + 1)'(QUEUE_SLOTS)) begin
      if (req_op == pqid_pkg::OP_PROBE_CQ) begin
        probe_hit = (cq_ids[probe_in] != '0);
      end else begin
        probe_hit = (sq_ids[probe_in] != '0);
      end
    end
  end

  always_comb begin
    sel_in    = sq_hit;
    pre_ok_in = 1'b1;
    unique case (req_op)
      pqid_pkg::OP_ADD_CQ: begin
        sel_in    = cq_free;
        pre_ok_in = (key_qid != '0) && !(|cq_hit);
      end
      pqid_pkg::OP_ADD_SQ,
      pqid_pkg::OP_FIND_CQ,
      pqid_pkg::OP_REMOVE_CQ: sel_in = cq_hit;
      pqid_pkg::OP_FIND_SQ,
      pqid_pkg::OP_REMOVE_SQ: sel_in = sq_hit;
      pqid_pkg::OP_PROBE_CQ,
      pqid_pkg::OP_PROBE_SQ:  pre_ok_in = probe_hit;
      default: begin
        sel_in    = sq_hit;
        pre_ok_in = 1'b1;
      end
    endcase
  end

  pqid_prio_enc #(
    .N (QUEUE_SLOTS),
    .W (SLOT_W)
  ) u_enc (
    .vec (sel_vec),
    .idx (enc_slot),
    .any (enc_any)
  );

  always_comb begin
    exec_ok   = enc_any;
    exec_slot = enc_slot;
    unique case (op)
      pqid_pkg::OP_ADD_CQ:    exec_ok = pre_ok && enc_any;
      pqid_pkg::OP_ADD_SQ:    exec_ok = enc_any && sq_free_vec[enc_slot];
      pqid_pkg::OP_FIND_CQ,
      pqid_pkg::OP_FIND_SQ,
      pqid_pkg::OP_REMOVE_CQ,
      pqid_pkg::OP_REMOVE_SQ: exec_ok = enc_any;
      pqid_pkg::OP_PROBE_CQ,
      pqid_pkg::OP_PROBE_SQ: begin
        exec_ok   = pre_ok;
        exec_slot = probe_idx;
      end
      default: exec_ok = enc_any;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pqid_pkg::ST_IDLE: if (in_fire) state_next = pqid_pkg::ST_EXEC;
      pqid_pkg::ST_EXEC: state_next = pqid_pkg::ST_RESP;
      pqid_pkg::ST_RESP: if (resp_go) state_next = pqid_pkg::ST_IDLE;
      default:           state_next = pqid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pqid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op          <= req_op;
      key         <= key_qid;
      new_sq      <= new_sq_qid;
      attr        <= attr_in[ATTR_BITS-1:0];
      probe_idx   <= probe_in;
      sel_vec     <= sel_in;
      sq_free_vec <= sq_free;
      pre_ok      <= pre_ok_in;
    end
  end

  // id tables, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        cq_ids[i] <= '0;
        sq_ids[i] <= '0;
      end
    end else if (state == pqid_pkg::ST_EXEC && exec_ok) begin
      unique case (op)
        pqid_pkg::OP_ADD_CQ:    cq_ids[exec_slot] <= key;
        pqid_pkg::OP_ADD_SQ:    sq_ids[exec_slot] <= new_sq;
        pqid_pkg::OP_REMOVE_CQ: cq_ids[exec_slot] <= '0;
        pqid_pkg::OP_REMOVE_SQ: sq_ids[exec_slot] <= '0;
        default: ;
      endcase
    end
  end

  // attribute memories, registered read
  always_ff @(posedge clk) begin
    if (state == pqid_pkg::ST_EXEC && exec_ok && op == pqid_pkg::OP_ADD_CQ) begin
      cq_attr_mem[exec_slot] <= attr;
    end
    cq_rd <= cq_attr_mem[enc_slot];
  end

  always_ff @(posedge clk) begin
    if (state == pqid_pkg::ST_EXEC && exec_ok && op == pqid_pkg::OP_ADD_SQ) begin
      sq_attr_mem[exec_slot] <= attr;
    end
    sq_rd <= sq_attr_mem[enc_slot];
  end

  always_ff @(posedge clk) begin
    if (state == pqid_pkg::ST_EXEC) begin
      res_ok   <= exec_ok;
      res_slot <= exec_ok ? exec_slot : '0;
      res_find <= exec_ok && (op == pqid_pkg::OP_FIND_CQ || op == pqid_pkg::OP_FIND_SQ);
      res_sq   <= (op == pqid_pkg::OP_FIND_SQ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_go) begin
      ok       <= res_ok;
      slot_out <= pqid_pkg::SLOT_BITS'(res_slot);
      if (res_find) begin
        attr_out <= pqid_pkg::WORD_BITS'(res_sq ? sq_rd : cq_rd);
      end else begin
        attr_out <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> slot_out == '0 && attr_out == '0)
    else $error("failed result carries slot or attribute");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == pqid_pkg::ST_EXEC)
    else $error("accepted word did not move to update step");

  a_add_cq_written: assert property (@(posedge clk) disable iff (rst)
    state == pqid_pkg::ST_EXEC && exec_ok && op == pqid_pkg::OP_ADD_CQ
    |=> cq_ids[$past(exec_slot)] == $past(key))
    else $error("added completion queue id not stored");

  a_attr_only_on_find: assert property (@(posedge clk) disable iff (rst)
    state == pqid_pkg::ST_EXEC && !exec_ok |=> !res_find && res_slot == '0)
    else $error("failed request marked as find hit");
`endif

endmodule

// ----- test/tb_paired_queue_id_table_unit.sv -----
`timescale 1ns / 1ps

module tb_paired_queue_id_table_unit;
  import pqid_pkg::*;

  localparam int SLOTS = 16;
  localparam int POOL = 24;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic                 ok;
    logic [SLOT_BITS-1:0] slot;
    logic [WORD_BITS-1:0] attr;
  } table_result_t;

  typedef enum {MIX_FILL, MIX_EVEN, MIX_EMPTY} mix_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           req_type = OP_FIND_CQ;
  logic [QID_BITS-1:0]  key_qid = '0;
  logic [QID_BITS-1:0]  new_sq_qid = '0;
  logic [SLOT_BITS-1:0] probe_slot = '0;
  logic [WORD_BITS-1:0] attr_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 ok;
  logic [SLOT_BITS-1:0] slot_out;
  logic [WORD_BITS-1:0] attr_out;

  // shadow copy of both queue tables
  logic [QID_BITS-1:0]  cq_tab [SLOTS];
  logic [QID_BITS-1:0]  sq_tab [SLOTS];
  logic [WORD_BITS-1:0] cq_attr_tab [SLOTS];
  logic [WORD_BITS-1:0] sq_attr_tab [SLOTS];

  table_result_t        pending_results [$];
  logic [QID_BITS-1:0]  id_pool [POOL];
  int                   error_count = 0;
  int                   burst_left = 0;
  int                   idle_cycles = 0;
  logic                 long_hold_req = 1'b0;
  int                   hold_left = 0;
  int                   segment_left = 0;
  int                   stall_pct = 0;

  paired_queue_id_table_unit #(
    .QUEUE_SLOTS(SLOTS),
    .ATTR_BITS  (WORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .key_qid   (key_qid),
    .new_sq_qid(new_sq_qid),
    .probe_slot(probe_slot),
    .attr_in   (attr_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .slot_out  (slot_out),
    .attr_out  (attr_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // lowest slot holding key, SLOTS when absent; key 0 never matches
  function automatic int lowest_match(bit sq_side, logic [QID_BITS-1:0] key);
    if (key == '0) return SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if ((sq_side ? sq_tab[i] : cq_tab[i]) == key) return i;
    end
    return SLOTS;
  endfunction

  function automatic int live_count(bit sq_side);
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((sq_side ? sq_tab[i] : cq_tab[i]) != '0) n++;
    end
    return n;
  endfunction

  function automatic table_result_t apply_request(op_t op, logic [QID_BITS-1:0] key,
      logic [QID_BITS-1:0] sqid, logic [SLOT_BITS-1:0] probe, logic [WORD_BITS-1:0] attr);
    table_result_t res;
    int s;
    res = '0;
    case (op)
      OP_ADD_CQ: begin
        if (key != '0 && lowest_match(1'b0, key) == SLOTS) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (cq_tab[i] == '0) begin
              cq_tab[i] = key;
              cq_attr_tab[i] = attr;
              res.ok = 1'b1;
              res.slot = SLOT_BITS'(i);
              break;
            end
          end
        end
      end
      OP_ADD_SQ: begin
        s = lowest_match(1'b0, key);
        if (s < SLOTS && sq_tab[s] == '0) begin
          // a zero sq id still writes the attribute and leaves the slot free
          sq_tab[s] = sqid;
          sq_attr_tab[s] = attr;
          res.ok = 1'b1;
          res.slot = SLOT_BITS'(s);
        end
      end
      OP_FIND_CQ, OP_FIND_SQ: begin
        s = lowest_match(op == OP_FIND_SQ, key);
        if (s < SLOTS) begin
          res.ok = 1'b1;
          res.slot = SLOT_BITS'(s);
          res.attr = (op == OP_FIND_SQ) ? sq_attr_tab[s] : cq_attr_tab[s];
        end
      end
      OP_REMOVE_CQ, OP_REMOVE_SQ: begin
        s = lowest_match(op == OP_REMOVE_SQ, key);
        if (s < SLOTS) begin
          if (op == OP_REMOVE_SQ) sq_tab[s] = '0;
          else cq_tab[s] = '0;
          res.ok = 1'b1;
          res.slot = SLOT_BITS'(s);
        end
      end
      default: begin
        if (probe < SLOTS && ((op == OP_PROBE_SQ) ? sq_tab[probe] : cq_tab[probe]) != '0) begin
          res.ok = 1'b1;
          res.slot = probe;
        end
      end
    endcase
    return res;
  endfunction

  // valid stays high on return; the next call lowers it at the end of a burst, or the drain does
  task automatic send_word(op_t op, logic [QID_BITS-1:0] key, logic [QID_BITS-1:0] sqid,
      logic [SLOT_BITS-1:0] probe, logic [WORD_BITS-1:0] attr);
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0:       burst_left = 200;
        1, 2, 3: burst_left = $urandom_range(1, 3);
        default: burst_left = $urandom_range(4, 20);
      endcase
      if (in_valid) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(13, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= op;
    key_qid    <= key;
    new_sq_qid <= sqid;
    probe_slot <= probe;
    attr_in    <= attr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(op, key, sqid, probe, attr));
  endtask

  task automatic wait_all_results();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [QID_BITS-1:0] pick_qid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 14) return QID_BITS'($urandom);
    return id_pool[$urandom_range(0, POOL - 1)];
  endfunction

  function automatic logic [QID_BITS-1:0] pick_live_id(bit sq_side);
    logic [QID_BITS-1:0] live [$];
    for (int i = 0; i < SLOTS; i++) begin
      if ((sq_side ? sq_tab[i] : cq_tab[i]) != '0) live.push_back(sq_side ? sq_tab[i] : cq_tab[i]);
    end
    if (live.size() == 0) return pick_qid();
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_attr();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [SLOT_BITS-1:0] pick_probe();
    if ($urandom_range(0, 99) < 85) return SLOT_BITS'($urandom_range(0, SLOTS + 1));
    return SLOT_BITS'($urandom);
  endfunction

  function automatic op_t pick_op(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 35) return OP_ADD_CQ;
        if (r < 60) return OP_ADD_SQ;
        if (r < 70) return OP_FIND_CQ;
        if (r < 80) return OP_FIND_SQ;
        if (r < 84) return OP_REMOVE_CQ;
        if (r < 88) return OP_REMOVE_SQ;
        if (r < 94) return OP_PROBE_CQ;
        return OP_PROBE_SQ;
      end
      MIX_EMPTY: begin
        if (r < 8) return OP_ADD_CQ;
        if (r < 16) return OP_ADD_SQ;
        if (r < 26) return OP_FIND_CQ;
        if (r < 36) return OP_FIND_SQ;
        if (r < 60) return OP_REMOVE_CQ;
        if (r < 84) return OP_REMOVE_SQ;
        if (r < 92) return OP_PROBE_CQ;
        return OP_PROBE_SQ;
      end
      default: return op_t'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_random_word(mix_t mix);
    op_t                 op;
    logic [QID_BITS-1:0] key;
    logic [QID_BITS-1:0] sqid;
    int                  r;
    op = pick_op(mix);
    r = $urandom_range(0, 99);
    case (op)
      OP_ADD_CQ:                key = (r < 15) ? pick_live_id(1'b0) : pick_qid();
      OP_ADD_SQ:                key = (r < 75) ? pick_live_id(1'b0) : pick_qid();
      OP_FIND_CQ, OP_REMOVE_CQ: key = (r < 65) ? pick_live_id(1'b0) : pick_qid();
      OP_FIND_SQ, OP_REMOVE_SQ: key = (r < 65) ? pick_live_id(1'b1) : pick_qid();
      default:                  key = pick_qid();
    endcase
    r = $urandom_range(0, 99);
    if (r < 5) sqid = '0;
    else if (r < 20) sqid = QID_BITS'($urandom);
    else sqid = id_pool[$urandom_range(0, POOL - 1)];
    send_word(op, key, sqid, pick_probe(), pick_attr());
  endtask

  task automatic test_special_cases();
    // zero keys fail on every add, find and remove
    send_word(OP_ADD_CQ, '0, 16'h0001, 8'h00, 64'h1111_2222_3333_4444);
    send_word(OP_ADD_SQ, '0, 16'h0001, 8'h00, 64'h0);
    send_word(OP_FIND_CQ, '0, '0, 8'h00, '0);
    send_word(OP_FIND_SQ, '0, '0, 8'h00, '0);
    send_word(OP_REMOVE_CQ, '0, '0, 8'h00, '0);
    send_word(OP_REMOVE_SQ, '0, '0, 8'h00, '0);
    send_word(OP_ADD_CQ, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
    send_word(OP_ADD_CQ, 16'hFFFF, '0, 8'h00, 64'h0123_4567_89AB_CDEF);
    send_word(OP_ADD_CQ, 16'h0001, '0, 8'h00, '0);
    // paired cq missing
    send_word(OP_ADD_SQ, 16'h1234, 16'h0042, 8'h00, '1);
    send_word(OP_ADD_SQ, 16'hFFFF, 16'hFFFF, 8'h00, 64'hA5A5_5A5A_F00F_0FF0);
    send_word(OP_ADD_SQ, 16'hFFFF, 16'h0077, 8'h00, '0);
    // zero sq id succeeds but leaves the slot free
    send_word(OP_ADD_SQ, 16'h0001, '0, 8'h00, 64'hDEAD_BEEF_0000_0001);
    send_word(OP_PROBE_SQ, 16'h0001, '0, 8'd1, '0);
    send_word(OP_ADD_SQ, 16'h0001, 16'hFFFF, 8'h00, 64'h8000_0000_0000_0001);
    send_word(OP_FIND_SQ, 16'hFFFF, '0, 8'h00, '0);
    send_word(OP_FIND_CQ, 16'h0001, '0, 8'h00, '1);
    // removing a cq keeps its paired sq
    send_word(OP_REMOVE_CQ, 16'hFFFF, '0, 8'h00, '0);
    send_word(OP_PROBE_SQ, '0, '0, 8'd0, '0);
    send_word(OP_PROBE_CQ, '0, '0, 8'd0, '0);
    send_word(OP_REMOVE_SQ, 16'hFFFF, '0, 8'h00, '0);
    send_word(OP_FIND_SQ, 16'hFFFF, '0, 8'h00, '0);
    send_word(OP_PROBE_CQ, '0, '0, 8'd1, '0);
    send_word(OP_PROBE_CQ, '0, '0, 8'(SLOTS), '0);
    send_word(OP_PROBE_SQ, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
  endtask

  task automatic test_full_table();
    int tries;
    for (int i = 0; i < SLOTS; i++) begin
      if (cq_tab[i] != '0) send_word(OP_REMOVE_CQ, cq_tab[i], pick_qid(), pick_probe(), pick_attr());
    end
    tries = 0;
    while (live_count(1'b0) < SLOTS && tries < 64) begin
      send_word(OP_ADD_CQ, QID_BITS'($urandom_range(1, 65535)), pick_qid(), pick_probe(),
                pick_attr());
      tries++;
    end
    send_word(OP_ADD_CQ, QID_BITS'($urandom_range(1, 65535)), '0, pick_probe(), pick_attr());
    send_word(OP_ADD_CQ, cq_tab[$urandom_range(0, SLOTS - 1)], '0, pick_probe(), pick_attr());
    for (int i = 0; i < SLOTS; i += 3) begin
      send_word(OP_ADD_SQ, cq_tab[i], pick_qid(), pick_probe(), pick_attr());
      send_word(OP_FIND_CQ, cq_tab[SLOTS - 1 - i], '0, pick_probe(), pick_attr());
    end
    for (int i = 0; i < SLOTS; i++) begin
      send_word(OP_REMOVE_CQ, cq_tab[i], pick_qid(), pick_probe(), pick_attr());
    end
  endtask

  // receiver holds off while words keep coming, so the input backs up
  task automatic test_long_stall();
    long_hold_req <= 1'b1;
    for (int i = 0; i < 15; i++) send_random_word(MIX_FILL);
  endtask

  task automatic test_random_mix(int count);
    int   sent;
    int   run;
    mix_t mix;
    sent = 0;
    while (sent < count) begin
      mix = mix_t'($urandom_range(0, 2));
      run = $urandom_range(40, 200);
      for (int i = 0; i < run && sent < count; i++) begin
        send_random_word(mix);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_all_results();
    end
  endtask

  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (segment_left == 0) begin
        segment_left <= $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 30;
          2:       stall_pct <= 70;
          default: stall_pct <= 90;
        endcase
      end else begin
        segment_left <= segment_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected, got ok %0b slot %0d attr %h",
                 $time, ok, slot_out, attr_out);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) begin
          error_count++;
          $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, ok);
        end
        if (slot_out !== want.slot) begin
          error_count++;
          $display("%0t: slot_out mismatch, expected %0d, got %0d", $time, want.slot, slot_out);
        end
        if (attr_out !== want.attr) begin
          error_count++;
          $display("%0t: attr_out mismatch, expected %h, got %h", $time, want.attr, attr_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("paired_queue_id_table_unit test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cq_tab[i] = '0;
      sq_tab[i] = '0;
      cq_attr_tab[i] = '0;
      sq_attr_tab[i] = '0;
    end
    for (int i = 0; i < POOL; i++) id_pool[i] = QID_BITS'($urandom_range(1, 65535));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    wait_all_results();
    test_full_table();
    wait_all_results();
    test_long_stall();
    test_random_mix(1700);
    wait_all_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("paired_queue_id_table_unit test passed");
    end else begin
      $display("paired_queue_id_table_unit test failed");
    end
    $finish;
  end

endmodule
